FILE: sv/asfhp_pkg.sv
package asfhp_pkg;

    localparam int ByteW = 8;
    localparam int WordW = 32;
    localparam int DurW  = 16;

    typedef enum logic [1:0] {
        SZ_NONE  = 2'd0,
        SZ_BYTE  = 2'd1,
        SZ_WORD  = 2'd2,
        SZ_DWORD = 2'd3
    } t_size;

    typedef struct packed {
        logic [ByteW-1:0] ltf_byte;
        logic [ByteW-1:0] prop_byte;
        logic [WordW-1:0] pkt_len;
        logic [WordW-1:0] sequence_number;
        logic [WordW-1:0] pad_len;
        logic [WordW-1:0] tx_stamp;
        logic [DurW-1:0]  duration;
        logic [ByteW-1:0] pay_flags;
        logic             status;
    } t_result;

endpackage

FILE: sv/asf_packet_header_parser.sv
// ASF data packet header parser.
// Input channel: one packet byte per beat on i_data_byte, with i_packet_start
// marking the first byte of a data packet; a beat moves on i_in_valid and
// o_in_ready both high. Output channel: one beat per completed header, on
// o_out_valid and i_out_ready, with all header fields as separate ports.
// Configuration: i_cfg_we writes i_cfg_wdata to the default packet length,
// used when the coded packet length is zero; write it only while idle.
// Throughput: one byte per cycle, unless the receiver stalls. Each byte
// lands in an input register and is then parsed by the header state machine,
// whose result goes to an output register. Bytes outside a header produce no
// beat.
// When the receiver stalls, the result is held and the input register still
// takes one more byte; parsing resumes as soon as the output slot frees.
// Reset (synchronous, active low) returns the parser to idle, clears the
// default packet length and drops any pending input or result beat.
module asf_packet_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_ltf_byte,
    output logic [7:0]  o_prop_byte,
    output logic [31:0] o_pkt_len,
    output logic [31:0] o_sequence_number,
    output logic [31:0] o_pad_len,
    output logic [31:0] o_tx_stamp,
    output logic [15:0] o_duration,
    output logic [7:0]  o_pay_flags,
    output logic        o_status
);
    import asfhp_pkg::*;

    logic [WordW-1:0] r_default_len;
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_start;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_adv;
    logic             w_emit;
    t_result          w_result;

    // input beat moves on when the output slot is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_len <= '0;
        end else if (i_cfg_we) begin
            r_default_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_packet_start;
        end
    end

    asfhp_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_data_byte    (r_in_byte),
        .i_packet_start (r_in_start),
        .i_dflt_len     (r_default_len),
        .o_emit         (w_emit),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ltf_byte        = r_out.ltf_byte;
    assign o_prop_byte       = r_out.prop_byte;
    assign o_pkt_len         = r_out.pkt_len;
    assign o_sequence_number = r_out.sequence_number;
    assign o_pad_len         = r_out.pad_len;
    assign o_tx_stamp        = r_out.tx_stamp;
    assign o_duration        = r_out.duration;
    assign o_pay_flags       = r_out.pay_flags;
    assign o_status          = r_out.status;

endmodule

FILE: sv/asfhp_parser.sv
module asfhp_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_packet_start,
    input  logic [31:0]               i_dflt_len,
    output logic                      o_emit,
    output asfhp_pkg::t_result        o_result
);
    import asfhp_pkg::*;

    typedef enum logic [10:0] {
        PH_IDLE = 11'b000_0000_0001,
        PH_SKIP = 11'b000_0000_0010,
        PH_LTF  = 11'b000_0000_0100,
        PH_PROP = 11'b000_0000_1000,
        PH_LEN  = 11'b000_0001_0000,
        PH_SEQ  = 11'b000_0010_0000,
        PH_PAD  = 11'b000_0100_0000,
        PH_TIME = 11'b000_1000_0000,
        PH_DUR  = 11'b001_0000_0000,
        PH_PFL  = 11'b010_0000_0000,
        PH_DONE = 11'b100_0000_0000
    } t_phase;

    // last byte of a field of the given size code
    function automatic logic field_last(input logic [1:0] code, input logic [2:0] cnt);
        logic res;
        begin
            case (t_size'(code))
                SZ_BYTE:  res = 1'b1;
                SZ_WORD:  res = (cnt == 3'd1);
                SZ_DWORD: res = (cnt == 3'd3);
                default:  res = 1'b0;
            endcase
            return res;
        end
    endfunction

    // first field after ph that carries bytes
    function automatic t_phase next_field(input logic [7:0] ltf, input t_phase ph);
        logic   has_len;
        logic   has_seq;
        logic   has_pad;
        t_phase res;
        begin
            has_len = (ltf[6:5] != SZ_NONE);
            has_seq = (ltf[2:1] != SZ_NONE);
            has_pad = (ltf[4:3] != SZ_NONE);
            res     = PH_TIME;
            case (ph)
                PH_PROP: begin
                    if (has_len)      res = PH_LEN;
                    else if (has_seq) res = PH_SEQ;
                    else if (has_pad) res = PH_PAD;
                end
                PH_LEN: begin
                    if (has_seq)      res = PH_SEQ;
                    else if (has_pad) res = PH_PAD;
                end
                PH_SEQ: begin
                    if (has_pad)      res = PH_PAD;
                end
                default: res = PH_TIME;
            endcase
            return res;
        end
    endfunction

    t_phase            r_phase, n_phase;
    logic [2:0]        r_byte_count, n_byte_count;
    logic [3:0]        r_skip_left, n_skip_left;
    logic [ByteW-1:0]  r_ltf, n_ltf;
    logic [ByteW-1:0]  r_prop, n_prop;
    logic [WordW-1:0]  r_len, n_len;
    logic [WordW-1:0]  r_seq, n_seq;
    logic [WordW-1:0]  r_pad, n_pad;
    logic [WordW-1:0]  r_time, n_time;
    logic [DurW-1:0]   r_dur, n_dur;
    logic [WordW-1:0]  w_lane;
    logic [ByteW-1:0]  w_pflags;
    logic [WordW-1:0]  w_plen;
    logic              w_emit;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_skip_left  = r_skip_left;
        n_ltf        = r_ltf;
        n_prop       = r_prop;
        n_len        = r_len;
        n_seq        = r_seq;
        n_pad        = r_pad;
        n_time       = r_time;
        n_dur        = r_dur;
        w_emit       = 1'b0;
        w_pflags     = '0;
        w_lane       = {24'd0, i_data_byte} << {r_byte_count[1:0], 3'b000};
        if (i_en) begin
            if (i_packet_start) begin
                n_byte_count = '0;
                if (i_data_byte[7]) begin
                    n_skip_left = i_data_byte[3:0];
                    n_phase     = (i_data_byte[3:0] != 4'd0) ? PH_SKIP : PH_LTF;
                end else begin
                    n_ltf   = i_data_byte;
                    n_phase = PH_PROP;
                end
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        n_skip_left = r_skip_left - 4'd1;
                        if (r_skip_left == 4'd1) n_phase = PH_LTF;
                    end
                    PH_LTF: begin
                        n_ltf   = i_data_byte;
                        n_phase = PH_PROP;
                    end
                    PH_PROP: begin
                        n_prop       = i_data_byte;
                        n_len        = '0;
                        n_seq        = '0;
                        n_pad        = '0;
                        n_time       = '0;
                        n_dur        = '0;
                        n_byte_count = '0;
                        n_phase      = next_field(r_ltf, PH_PROP);
                    end
                    PH_LEN: begin
                        n_len        = r_len | w_lane;
                        n_byte_count = r_byte_count + 3'd1;
                        if (field_last(r_ltf[6:5], r_byte_count)) begin
                            n_byte_count = '0;
                            n_phase      = next_field(r_ltf, PH_LEN);
                        end
                    end
                    PH_SEQ: begin
                        n_seq        = r_seq | w_lane;
                        n_byte_count = r_byte_count + 3'd1;
                        if (field_last(r_ltf[2:1], r_byte_count)) begin
                            n_byte_count = '0;
                            n_phase      = next_field(r_ltf, PH_SEQ);
                        end
                    end
                    PH_PAD: begin
                        n_pad        = r_pad | w_lane;
                        n_byte_count = r_byte_count + 3'd1;
                        if (field_last(r_ltf[4:3], r_byte_count)) begin
                            n_byte_count = '0;
                            n_phase      = PH_TIME;
                        end
                    end
                    PH_TIME: begin
                        n_time       = r_time | w_lane;
                        n_byte_count = r_byte_count + 3'd1;
                        if (field_last(SZ_DWORD, r_byte_count)) begin
                            n_byte_count = '0;
                            n_phase      = PH_DUR;
                        end
                    end
                    PH_DUR: begin
                        n_dur        = r_dur | w_lane[DurW-1:0];
                        n_byte_count = r_byte_count + 3'd1;
                        if (field_last(SZ_WORD, r_byte_count)) begin
                            n_byte_count = '0;
                            if (r_ltf[0]) begin
                                n_phase = PH_PFL;
                            end else begin
                                n_phase = PH_DONE;
                                w_emit  = 1'b1;
                            end
                        end
                    end
                    PH_PFL: begin
                        w_pflags = i_data_byte;
                        w_emit   = 1'b1;
                        n_phase  = PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // coded zero length falls back to the configured default
    assign w_plen = (n_len == '0) ? i_dflt_len : n_len;

    always_comb begin
        o_result.ltf_byte        = n_ltf;
        o_result.prop_byte       = n_prop;
        o_result.pkt_len         = w_plen;
        o_result.sequence_number = n_seq;
        o_result.pad_len         = n_pad;
        o_result.tx_stamp        = n_time;
        o_result.duration        = n_dur;
        o_result.pay_flags       = w_pflags;
        o_result.status          = (n_pad > w_plen);
    end

    assign o_emit = w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_skip_left  <= '0;
            r_ltf        <= '0;
            r_prop       <= '0;
            r_len        <= '0;
            r_seq        <= '0;
            r_pad        <= '0;
            r_time       <= '0;
            r_dur        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_skip_left  <= n_skip_left;
            r_ltf        <= n_ltf;
            r_prop       <= n_prop;
            r_len        <= n_len;
            r_seq        <= n_seq;
            r_pad        <= n_pad;
            r_time       <= n_time;
            r_dur        <= n_dur;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parser phase not one-hot");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_phase == PH_DONE))
        else $error("phase not done after result");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip_left != 4'd0))
        else $error("skip phase with empty count");

    a_dur_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DUR) |-> (r_byte_count < 3'd2))
        else $error("duration byte count out of range");

endmodule

FILE: test/asf_packet_header_parser_tb.sv
`timescale 1ns / 100ps

module asf_packet_header_parser_tb;
    import asfhp_pkg::*;

    typedef enum logic [3:0] {
        P_IDLE, P_SKIP, P_LTF, P_PROP, P_LEN, P_SEQ, P_PAD, P_TIME, P_DUR, P_PFL, P_DONE
    } t_hdr_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        t_result    hdr;
    } t_beat_row;

    localparam t_result NO_HDR  = '0;
    localparam t_result ERR_HDR = '{8'hA9, 8'hFF, 32'h10, 32'h0, 32'hFF, 32'h0, 16'h0,
                                    8'hFF, 1'b1};
    localparam t_result MAX_HDR = '{8'h00, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                    16'hFFFF, 8'h00, 1'b0};
    localparam int NUM_DIR    = 26;
    localparam int NUM_PHASES = 5;
    localparam int PHASE_BEATS = 160;

    localparam t_beat_row DIR_ROWS [NUM_DIR] = '{
        '{8'hAA, 1'b0, 1'b0, NO_HDR},
        '{8'h80, 1'b1, 1'b0, NO_HDR},
        '{8'hA9, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'h10, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b1, ERR_HDR},
        '{8'h55, 1'b0, 1'b0, NO_HDR},
        '{8'h81, 1'b1, 1'b0, NO_HDR},
        '{8'h12, 1'b0, 1'b0, NO_HDR},
        '{8'h04, 1'b0, 1'b0, NO_HDR},
        '{8'h33, 1'b0, 1'b0, NO_HDR},
        '{8'h00, 1'b1, 1'b0, NO_HDR},
        '{8'h00, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b0, NO_HDR},
        '{8'hFF, 1'b0, 1'b1, MAX_HDR}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_packet_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_ltf_byte;
    logic [7:0]  o_prop_byte;
    logic [31:0] o_pkt_len;
    logic [31:0] o_sequence_number;
    logic [31:0] o_pad_len;
    logic [31:0] o_tx_stamp;
    logic [15:0] o_duration;
    logic [7:0]  o_pay_flags;
    logic        o_status;

    logic        row_typed;
    t_result     row_hdr;

    bit          gaps_on;
    bit          hold_off_req;
    int          mismatch_count;
    int          items_sent;

    // parser mirror
    t_hdr_phase  hdr_phase;
    logic [2:0]  field_pos;
    logic [3:0]  ec_left;
    logic [7:0]  ltf_q;
    logic [7:0]  prop_q;
    logic [31:0] len_word;
    logic [31:0] seq_word;
    logic [31:0] pad_word;
    logic [31:0] time_word;
    logic [15:0] dur_half;
    logic [31:0] dflt_len;
    t_result     pending_headers[$];

    asf_packet_header_parser uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_packet_start    (i_packet_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_ltf_byte        (o_ltf_byte),
        .o_prop_byte       (o_prop_byte),
        .o_pkt_len         (o_pkt_len),
        .o_sequence_number (o_sequence_number),
        .o_pad_len         (o_pad_len),
        .o_tx_stamp        (o_tx_stamp),
        .o_duration        (o_duration),
        .o_pay_flags       (o_pay_flags),
        .o_status          (o_status)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int code_len(t_size code);
        case (code)
            SZ_NONE: return 0;
            SZ_BYTE: return 1;
            SZ_WORD: return 2;
            default: return 4;
        endcase
    endfunction

    function automatic int field_len(t_hdr_phase p);
        case (p)
            P_LEN:   return code_len(t_size'(ltf_q[6:5]));
            P_SEQ:   return code_len(t_size'(ltf_q[2:1]));
            P_PAD:   return code_len(t_size'(ltf_q[4:3]));
            P_TIME:  return 4;
            P_DUR:   return 2;
            P_PFL:   return int'(ltf_q[0]);
            default: return 0;
        endcase
    endfunction

    function automatic t_hdr_phase first_field(t_hdr_phase p);
        while (p != P_DONE && field_len(p) == 0) begin
            p = t_hdr_phase'(p + 1);
        end
        return p;
    endfunction

    function automatic t_result header_result(logic [7:0] pfl);
        t_result r;
        r.ltf_byte        = ltf_q;
        r.prop_byte       = prop_q;
        r.pkt_len         = (len_word == 32'h0) ? dflt_len : len_word;
        r.sequence_number = seq_word;
        r.pad_len         = pad_word;
        r.tx_stamp        = time_word;
        r.duration        = dur_half;
        r.pay_flags       = pfl;
        r.status          = (pad_word > r.pkt_len);
        return r;
    endfunction

    task automatic reset_parser_mirror();
        hdr_phase = P_IDLE;
        field_pos = '0;
        ec_left   = '0;
        ltf_q     = '0;
        prop_q    = '0;
        len_word  = '0;
        seq_word  = '0;
        pad_word  = '0;
        time_word = '0;
        dur_half  = '0;
        dflt_len  = '0;
        pending_headers.delete();
    endtask

    task automatic parse_header_byte(input logic [7:0] b, input logic start,
                                     output bit emitted, output t_result hdr);
        emitted = 1'b0;
        hdr     = '0;
        if (start) begin
            field_pos = '0;
            if (b[7]) begin
                ec_left   = b[3:0];
                hdr_phase = (b[3:0] != 4'h0) ? P_SKIP : P_LTF;
            end else begin
                ltf_q     = b;
                hdr_phase = P_PROP;
            end
        end else begin
            case (hdr_phase)
                P_SKIP: begin
                    ec_left = ec_left - 4'h1;
                    if (ec_left == 4'h0)
                        hdr_phase = P_LTF;
                end
                P_LTF: begin
                    ltf_q     = b;
                    hdr_phase = P_PROP;
                end
                P_PROP: begin
                    prop_q    = b;
                    len_word  = '0;
                    seq_word  = '0;
                    pad_word  = '0;
                    time_word = '0;
                    dur_half  = '0;
                    field_pos = '0;
                    hdr_phase = first_field(P_LEN);
                end
                P_LEN, P_SEQ, P_PAD, P_TIME, P_DUR: begin
                    case (hdr_phase)
                        P_LEN:   len_word[8*field_pos[1:0] +: 8] = b;
                        P_SEQ:   seq_word[8*field_pos[1:0] +: 8] = b;
                        P_PAD:   pad_word[8*field_pos[1:0] +: 8] = b;
                        P_TIME:  time_word[8*field_pos[1:0] +: 8] = b;
                        default: dur_half[8*field_pos[0] +: 8] = b;
                    endcase
                    field_pos = field_pos + 3'd1;
                    if (int'(field_pos) >= field_len(hdr_phase)) begin
                        field_pos = '0;
                        hdr_phase = first_field(t_hdr_phase'(hdr_phase + 1));
                        if (hdr_phase == P_DONE) begin
                            emitted = 1'b1;
                            hdr     = header_result(8'h00);
                        end
                    end
                end
                P_PFL: begin
                    emitted   = 1'b1;
                    hdr       = header_result(b);
                    hdr_phase = P_DONE;
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_error(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            report_error($sformatf("%s: got %h, want %h", name, got_v, want_v));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        bit      emitted;
        if (!i_rst_n) begin
            reset_parser_mirror();
        end else begin
            if (i_cfg_we)
                dflt_len = i_cfg_wdata;
            if (o_out_valid && i_out_ready) begin
                got = '{o_ltf_byte, o_prop_byte, o_pkt_len,
                        o_sequence_number, o_pad_len, o_tx_stamp, o_duration,
                        o_pay_flags, o_status};
                if (pending_headers.size() == 0) begin
                    report_error("result beat with no header pending");
                end else begin
                    want = pending_headers.pop_front();
                    check_field("ltf_byte", 32'(got.ltf_byte), 32'(want.ltf_byte));
                    check_field("prop_byte", 32'(got.prop_byte), 32'(want.prop_byte));
                    check_field("pkt_len", got.pkt_len, want.pkt_len);
                    check_field("sequence_number", got.sequence_number,
                                want.sequence_number);
                    check_field("pad_len", got.pad_len, want.pad_len);
                    check_field("tx_stamp", got.tx_stamp, want.tx_stamp);
                    check_field("duration", 32'(got.duration), 32'(want.duration));
                    check_field("pay_flags", 32'(got.pay_flags), 32'(want.pay_flags));
                    check_field("status", 32'(got.status), 32'(want.status));
                end
            end
            if (i_in_valid && o_in_ready) begin
                parse_header_byte(i_data_byte, i_packet_start, emitted, predicted);
                if (emitted)
                    pending_headers = {pending_headers, (row_typed ? row_hdr : predicted)};
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic start, input logic typed,
                             input t_result hdr);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_packet_start <= start;
        row_typed      <= typed;
        row_hdr        <= hdr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_field_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_packet();
        logic [7:0] hdr_bytes[$];
        logic [7:0] first;
        logic [7:0] ltf_b;
        int         ec;
        int         cut;
        int         n;
        hdr_bytes = {};
        if ($urandom_range(0, 1) == 0) begin
            ltf_b    = 8'($urandom);
            ltf_b[7] = 1'b0;
            hdr_bytes = {hdr_bytes, ltf_b};
        end else begin
            ec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            first       = 8'($urandom);
            first[7]    = 1'b1;
            first[3:0]  = 4'(ec);
            hdr_bytes = {hdr_bytes, first};
            repeat (ec) hdr_bytes = {hdr_bytes, 8'($urandom)};
            ltf_b = 8'($urandom);
            hdr_bytes = {hdr_bytes, ltf_b};
        end
        hdr_bytes = {hdr_bytes, 8'($urandom)};
        n = code_len(t_size'(ltf_b[6:5])) + code_len(t_size'(ltf_b[2:1]))
            + code_len(t_size'(ltf_b[4:3])) + 6 + int'(ltf_b[0]);
        repeat (n) hdr_bytes = {hdr_bytes, rand_field_byte()};
        // broken header now and then, cut short by the next start
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hdr_bytes.size() - 1)
                                          : hdr_bytes.size();
        for (int k = 0; k < cut; k++)
            send_beat(hdr_bytes[k], (k == 0), 1'b0, NO_HDR);
        items_sent += cut;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0, 1'b0, NO_HDR);
    endtask

    task automatic drain_pipeline();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_headers.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_default_len(input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [31:0] dflt_vals[NUM_PHASES];
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_data_byte    <= '0;
        i_packet_start <= 1'b0;
        row_typed      <= 1'b0;
        row_hdr        <= '0;
        gaps_on        = 1'b1;
        hold_off_req   = 1'b0;
        mismatch_count = 0;
        dflt_vals[0] = 32'hFFFF_FFFF;
        dflt_vals[1] = 32'h0000_0000;
        dflt_vals[2] = $urandom;
        dflt_vals[3] = 32'h0000_0001;
        dflt_vals[4] = 32'h8000_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++)
            send_beat(DIR_ROWS[k].data, DIR_ROWS[k].start, DIR_ROWS[k].typed, DIR_ROWS[k].hdr);
        drain_pipeline();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_default_len(dflt_vals[p]);
            if (p == NUM_PHASES - 1)
                gaps_on = 1'b0;
            if (p == 2)
                hold_off_req = 1'b1;
            items_sent = 0;
            while (items_sent < PHASE_BEATS)
                send_random_packet();
            drain_pipeline();
        end

        if (pending_headers.size() != 0)
            report_error($sformatf("%0d header results never arrived", pending_headers.size()));
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: asf_packet_header_parser.f
sv/asfhp_pkg.sv
sv/asfhp_parser.sv
sv/asf_packet_header_parser.sv
test/asf_packet_header_parser_tb.sv
